FILE: sv/tkm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the timestamp k-way merge.
package tkm_pkg;

  localparam int MAX_STREAMS_DEFAULT = 16;

  localparam int CLOCK_W = 64;
  localparam int FIELD_W = 8;

  // One stored head event of a stream.
  typedef struct packed {
    logic [CLOCK_W-1:0] clock;
    logic [FIELD_W-1:0] fsm;
    logic [FIELD_W-1:0] code;
  } head_t;

endpackage

FILE: sv/timestamp_kway_merge.sv
`timescale 1ns / 1ps
// Top level of the timestamp k-way merge.
//
// This block merges up to MAX_STREAMS per-stream event sequences into one
// sequence ordered by timestamp. Each input word either delivers the next
// event of a stream that is waiting for one, or marks that stream as ended;
// a word for a stream outside the configured count, or for a stream that
// already holds a head or has ended, is dropped. Heads live in a small RAM
// and a per-stream status register. After every input word the block walks
// the live streams with a single 64-bit comparator, one RAM read per cycle;
// if any live stream is still waiting the walk stops and nothing is sent.
// Otherwise the smallest clock wins (the lowest index on ties) and one
// output word is sent, carrying the clock relative to the first clock ever
// sent and a flag that is set when the clock does not exceed the previous
// one sent. The stall on the input channel stays high from the cycle after
// an accepted word until the walk is over and any word it picked has moved
// into the output register, which waits while that register is full and
// stalled, so a new word is taken only once the last one is through. The
// output register lets the next input word in while a finished word still
// waits downstream. The stream count register may be written whenever
// reset is low, but must be changed only while the block is idle; 0 counts
// as one stream and values above MAX_STREAMS count as MAX_STREAMS. Once all
// live streams have ended, nothing more is sent until reset.
module timestamp_kway_merge #(
  parameter int MAX_STREAMS = tkm_pkg::MAX_STREAMS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  stream_count,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  stream_index,
  input  logic [63:0] event_clock,
  input  logic [7:0]  event_fsm,
  input  logic [7:0]  event_code,
  input  logic        stream_ends,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  source_stream,
  output logic signed [63:0] time_delta,
  output logic [7:0]  fsm_out,
  output logic [7:0]  code_out,
  output logic        time_backwards
);

  localparam int IDX_W = $clog2(MAX_STREAMS);
  localparam int CNT_W = $clog2(MAX_STREAMS + 1);

  // Per-stream status codes.
  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_HOLD = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state;
  logic [4:0]       count_reg;
  logic [CNT_W-1:0] live_n;
  logic [1:0]       status [MAX_STREAMS];

  logic [CNT_W-1:0] scan_idx;
  logic             cmp_v;
  logic [IDX_W-1:0] cmp_idx;
  logic [1:0]       cmp_status;
  logic             pick_v;
  logic [IDX_W-1:0] pick_idx;
  tkm_pkg::head_t   best;

  logic        first_seen;
  logic [63:0] first_clock;
  logic [63:0] previous_clock;

  logic             in_take;
  logic             in_live;
  logic [IDX_W-1:0] in_slot;
  logic             in_open;
  logic             issue;
  logic [IDX_W-1:0] rd_addr;
  tkm_pkg::head_t   rd_data;
  tkm_pkg::head_t   wr_data;
  logic             wr_en;
  logic             take_pick;
  logic             emit_fire;
  logic [63:0]      first_base;

  // Effective number of streams taking part.
  always_comb begin
    if (count_reg == 5'd0) begin
      live_n = CNT_W'(1);
    end else if (int'(count_reg) > MAX_STREAMS) begin
      live_n = CNT_W'(MAX_STREAMS);
    end else begin
      live_n = CNT_W'(count_reg);
    end
  end

  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;

  // A word only lands when its stream takes part and is waiting.
  assign in_live = int'(stream_index) < int'(live_n);
  assign in_slot = IDX_W'(stream_index);
  assign in_open = in_live && (status[in_slot] == ST_WAIT);
  assign wr_en   = in_take && in_open && !stream_ends;
  assign wr_data = '{clock: event_clock, fsm: event_fsm, code: event_code};

  // The walk issues one RAM read per cycle; the compare runs in the cycle after the read.
  assign issue   = (state == S_SCAN) && (scan_idx < live_n);
  assign rd_addr = scan_idx[IDX_W-1:0];

  assign take_pick = (state == S_SCAN) && cmp_v && (cmp_status == ST_HOLD) &&
                     (!pick_v || (rd_data.clock < best.clock));

  assign emit_fire  = (state == S_EMIT) && (!out_valid || !out_stall);
  assign first_base = first_seen ? first_clock : best.clock;

  tkm_head_ram #(
    .DEPTH  (MAX_STREAMS),
    .ADDR_W (IDX_W)
  ) u_head_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_slot),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count_reg      <= 5'd1;
      scan_idx       <= '0;
      cmp_v          <= 1'b0;
      pick_v         <= 1'b0;
      out_valid      <= 1'b0;
      first_seen     <= 1'b0;
      first_clock    <= '0;
      previous_clock <= '0;
      for (int i = 0; i < MAX_STREAMS; i++) begin
        status[i] <= ST_WAIT;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        count_reg <= stream_count;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (in_open) begin
              status[in_slot] <= stream_ends ? ST_END : ST_HOLD;
            end
            state    <= S_SCAN;
            scan_idx <= '0;
            cmp_v    <= 1'b0;
            pick_v   <= 1'b0;
          end
        end
        S_SCAN: begin
          cmp_v <= issue;
          if (issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (cmp_v) begin
            if (cmp_status == ST_WAIT) begin
              // A live stream still waits: nothing can be sent yet.
              state <= S_IDLE;
            end else if (take_pick) begin
              pick_v <= 1'b1;
            end
          end else if (!issue) begin
            state <= pick_v ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            first_seen       <= 1'b1;
            previous_clock   <= best.clock;
            status[pick_idx] <= ST_WAIT;
            if (!first_seen) begin
              first_clock <= best.clock;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx    <= rd_addr;
      cmp_status <= status[rd_addr];
    end
    if (take_pick) begin
      best     <= rd_data;
      pick_idx <= cmp_idx;
    end
    if (emit_fire) begin
      source_stream  <= 4'(pick_idx);
      time_delta     <= $signed(best.clock - first_base);
      fsm_out        <= best.fsm;
      code_out       <= best.code;
      time_backwards <= previous_clock >= best.clock;
    end
  end

endmodule

FILE: sv/tkm_head_ram.sv
`timescale 1ns / 1ps
// Head event store: one write port, one read port with registered data.
module tkm_head_ram #(
  parameter int DEPTH  = tkm_pkg::MAX_STREAMS_DEFAULT,
  parameter int ADDR_W = $clog2(tkm_pkg::MAX_STREAMS_DEFAULT)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  tkm_pkg::head_t    wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output tkm_pkg::head_t    rd_data
);

  tkm_pkg::head_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/tkm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the timestamp k-way merge, bound to the top level.
module tkm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  source_stream,
  input logic [63:0] time_delta,
  input logic [7:0]  fsm_out,
  input logic [7:0]  code_out,
  input logic        time_backwards
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(source_stream) &&
      $stable(time_delta) && $stable(fsm_out) && $stable(code_out) &&
      $stable(time_backwards))
    else $error("stalled output word changed");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // Once a word is taken, the block is busy walking the heads.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted word");

  // A new output word only appears at the end of a walk.
  a_emit_after_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word appeared while idle");

endmodule

bind timestamp_kway_merge tkm_checker u_tkm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .source_stream  (source_stream),
  .time_delta     (time_delta),
  .fsm_out        (fsm_out),
  .code_out       (code_out),
  .time_backwards (time_backwards)
);

FILE: dv/timestamp_kway_merge_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timestamp k-way merge with its own merge predictor.
module timestamp_kway_merge_test;

  // Idle draws run from zero to this many cycles per word on either side.
  localparam int GAP_MAX = 17;
  // Leaves margin after the longest walk, before a register write and at the
  // end of the run.
  localparam int SETTLE_CYCLES = 40;
  // Length of the long downstream hold-off.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  // Per-stream state of the predictor.
  typedef enum logic [1:0] {
    LANE_WAIT,
    LANE_HOLD,
    LANE_DONE
  } lane_state_t;

  // One input word: either the next event of a stream or its end mark.
  typedef struct packed {
    logic [3:0]                  idx;
    logic [tkm_pkg::CLOCK_W-1:0] clock;
    logic [tkm_pkg::FIELD_W-1:0] fsm;
    logic [tkm_pkg::FIELD_W-1:0] code;
    logic                        ends;
  } event_word_t;

  // One merged output word.
  typedef struct packed {
    logic [3:0]                  src;
    logic [tkm_pkg::CLOCK_W-1:0] delta;
    logic [tkm_pkg::FIELD_W-1:0] fsm;
    logic [tkm_pkg::FIELD_W-1:0] code;
    logic                        backwards;
  } merged_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  stream_count;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  stream_index;
  logic [63:0] event_clock;
  logic [7:0]  event_fsm;
  logic [7:0]  event_code;
  logic        stream_ends;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  source_stream;
  logic signed [63:0] time_delta;
  logic [7:0]  fsm_out;
  logic [7:0]  code_out;
  logic        time_backwards;

  // Predictor state: one head and one status per stream, the clock of the
  // very first merged word, the clock of the last merged word, and the
  // stream count register as last written.
  tkm_pkg::head_t              heads [tkm_pkg::MAX_STREAMS_DEFAULT];
  lane_state_t                 lane_state [tkm_pkg::MAX_STREAMS_DEFAULT];
  logic [tkm_pkg::CLOCK_W-1:0] origin_clock;
  bit                          origin_taken;
  logic [tkm_pkg::CLOCK_W-1:0] last_merged_clock;
  logic [4:0]                  merge_width;

  // Merged words still owed by the block, oldest first.
  merged_word_t merged_q [$];

  // Source of mostly rising event clocks for the random traffic.
  logic [tkm_pkg::CLOCK_W-1:0] clock_cursor = 64'd1000;

  bit sender_idles;
  bit receiver_idles;
  bit hold_req;
  bit hold_active;
  int error_count;
  int quiet_cycles;

  timestamp_kway_merge #(
    .MAX_STREAMS(tkm_pkg::MAX_STREAMS_DEFAULT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .stream_count  (stream_count),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .stream_index  (stream_index),
    .event_clock   (event_clock),
    .event_fsm     (event_fsm),
    .event_code    (event_code),
    .stream_ends   (stream_ends),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .source_stream (source_stream),
    .time_delta    (time_delta),
    .fsm_out       (fsm_out),
    .code_out      (code_out),
    .time_backwards(time_backwards)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // Streams taking part: a count of zero still means one stream, and the
  // count saturates at the number of streams the block was built with.
  function automatic int live_streams();
    if (int'(merge_width) == 0) return 1;
    if (int'(merge_width) > tkm_pkg::MAX_STREAMS_DEFAULT) return tkm_pkg::MAX_STREAMS_DEFAULT;
    return int'(merge_width);
  endfunction

  // Applies one accepted word to the predicted state. Returns 1 and the
  // merged word when the word lets the block emit.
  function automatic bit predict_merge(input event_word_t w, output merged_word_t r);
    int                          n;
    int                          pick;
    logic [tkm_pkg::CLOCK_W-1:0] best;
    n    = live_streams();
    pick = -1;
    best = '0;
    r    = '0;
    // Words for streams outside the count, or for streams that already
    // hold a head or have ended, leave the state alone.
    if (int'(w.idx) < n && lane_state[w.idx] == LANE_WAIT) begin
      if (w.ends) begin
        lane_state[w.idx] = LANE_DONE;
      end else begin
        heads[w.idx].clock = w.clock;
        heads[w.idx].fsm   = w.fsm;
        heads[w.idx].code  = w.code;
        lane_state[w.idx]  = LANE_HOLD;
      end
    end
    // The merge runs after every word, ignored ones too. Any stream still
    // waiting blocks it; strict less-than keeps the lowest index on ties.
    for (int i = 0; i < n; i++) begin
      if (lane_state[i] == LANE_WAIT) return 1'b0;
      if (lane_state[i] == LANE_HOLD && (pick < 0 || heads[i].clock < best)) begin
        pick = i;
        best = heads[i].clock;
      end
    end
    if (pick < 0) return 1'b0;
    if (!origin_taken) begin
      origin_clock = best;
      origin_taken = 1'b1;
    end
    r.src       = pick[3:0];
    r.delta     = best - origin_clock;
    r.fsm       = heads[pick].fsm;
    r.code      = heads[pick].code;
    // The last clock starts at zero, so a first clock of zero is flagged.
    r.backwards = (last_merged_clock >= best);
    last_merged_clock = best;
    lane_state[pick]  = LANE_WAIT;
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  function automatic event_word_t event_word(input logic [3:0] idx,
                                             input logic [tkm_pkg::CLOCK_W-1:0] clock,
                                             input logic [tkm_pkg::FIELD_W-1:0] fsm,
                                             input logic [tkm_pkg::FIELD_W-1:0] code,
                                             input logic ends);
    event_word_t w;
    w.idx   = idx;
    w.clock = clock;
    w.fsm   = fsm;
    w.code  = code;
    w.ends  = ends;
    return w;
  endfunction

  // Mostly small steps up from the cursor, which gives plenty of ties.
  // Now and then a clock falls back a little, or is drawn over the whole
  // 64-bit range so every bit toggles and the delta can wrap.
  function automatic logic [tkm_pkg::CLOCK_W-1:0] fresh_clock();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return {$urandom, $urandom};
    if (roll == 1) return clock_cursor - tkm_pkg::CLOCK_W'($urandom_range(0, 20));
    clock_cursor += tkm_pkg::CLOCK_W'($urandom_range(0, 40));
    return clock_cursor;
  endfunction

  // A random live stream that is waiting for its next event, or -1.
  function automatic int random_waiting_stream();
    int pool [$];
    int n;
    n = live_streams();
    for (int i = 0; i < n; i++) begin
      if (lane_state[i] == LANE_WAIT) pool.push_back(i);
    end
    if (pool.size() == 0) return -1;
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  function automatic bit all_live_ended();
    int n;
    n = live_streams();
    for (int i = 0; i < n; i++) begin
      if (lane_state[i] != LANE_DONE) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Nine words in ten feed a waiting stream; the rest go to any index with
  // random content. Outside the ending phase a stray end mark must never
  // land on a waiting live stream, since an ended stream stays ended.
  function automatic event_word_t make_event_word(input int end_odds, output bit useful);
    event_word_t w;
    int          s;
    s       = random_waiting_stream();
    w.fsm   = tkm_pkg::FIELD_W'($urandom);
    w.code  = tkm_pkg::FIELD_W'($urandom);
    w.clock = fresh_clock();
    w.ends  = 1'b0;
    useful  = 1'b0;
    if (s >= 0 && $urandom_range(0, 9) != 0) begin
      w.idx  = 4'(s);
      useful = 1'b1;
      if (end_odds > 0 && $urandom_range(1, end_odds) == 1) w.ends = 1'b1;
    end else begin
      w.idx  = 4'($urandom_range(0, 15));
      w.ends = 1'($urandom_range(0, 1));
      if (end_odds == 0 && int'(w.idx) < live_streams() &&
          lane_state[w.idx] == LANE_WAIT) begin
        w.ends = 1'b0;
      end
    end
    return w;
  endfunction

  // Offers one word and holds it until the block takes it. Valid stays high
  // straight into the next word when no idle cycles are drawn.
  task automatic send_event_word(input event_word_t w);
    int           gap;
    merged_word_t res;
    gap = sender_idles ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_index <= w.idx;
    event_clock  <= w.clock;
    event_fsm    <= w.fsm;
    event_code   <= w.code;
    stream_ends  <= w.ends;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_merge(w, res)) merged_q.push_back(res);
  endtask

  // Stops offering words until every owed word has come out, then gives
  // the block time to finish a walk that emits nothing.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The count register is only written while the block is idle.
  task automatic write_stream_count(input logic [4:0] value);
    wait_for_drain();
    stream_count <= value;
    cfg_valid    <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    merge_width  = value;
  endtask

  // Random traffic; only words aimed at a waiting stream count toward the
  // total. Stops early once every live stream has ended.
  task automatic run_traffic(input int words, input int end_odds);
    event_word_t w;
    bit          useful;
    int          done;
    done = 0;
    while (done < words && !all_live_ended()) begin
      w = make_event_word(end_odds, useful);
      send_event_word(w);
      if (useful) done++;
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Reset count of one: every event on stream 0 merges at once. Covers the
  // zero first clock, the clock extremes, equal and falling clocks, and
  // words for streams outside the count.
  task automatic test_single_stream();
    send_event_word(event_word(4'd0, 64'd0, 8'h00, 8'h00, 1'b0));
    send_event_word(event_word(4'd5, {$urandom, $urandom}, 8'hFF, 8'hFF, 1'b1));
    send_event_word(event_word(4'd0, '1, 8'hFF, 8'hFF, 1'b0));
    send_event_word(event_word(4'd0, '1, 8'h5A, 8'hA5, 1'b0));
    send_event_word(event_word(4'd0, 64'd1, 8'h0F, 8'hF0, 1'b0));
    send_event_word(event_word(4'd15, {$urandom, $urandom}, 8'h33, 8'hCC, 1'b0));
  endtask

  // A count of zero behaves as one stream.
  task automatic test_zero_count();
    write_stream_count(5'd0);
    send_event_word(event_word(4'd0, 64'h8000_0000_0000_0000, 8'h80, 8'h01, 1'b0));
    send_event_word(event_word(4'd1, 64'd42, 8'h11, 8'h22, 1'b0));
  endtask

  // Two streams: a second event for a stream that already holds a head is
  // dropped, and equal clocks go to the lower index.
  task automatic test_two_streams();
    write_stream_count(5'd2);
    send_event_word(event_word(4'd0, 64'd500, 8'h01, 8'h10, 1'b0));
    send_event_word(event_word(4'd0, 64'd3, 8'h02, 8'h20, 1'b0));
    send_event_word(event_word(4'd1, 64'd500, 8'h03, 8'h30, 1'b0));
    send_event_word(event_word(4'd0, 64'd500, 8'h04, 8'h40, 1'b0));
    send_event_word(event_word(4'd0, 64'd499, 8'h05, 8'h50, 1'b0));
    send_event_word(event_word(4'd0, 64'd600, 8'h06, 8'h60, 1'b0));
    send_event_word(event_word(4'd1, 64'd600, 8'h07, 8'h70, 1'b0));
    send_event_word(event_word(4'd2, 64'd1, 8'h08, 8'h80, 1'b0));
  endtask

  // All sixteen streams. The first fill goes in index order so that every
  // head has been written before the merge has to look at it.
  task automatic test_full_width();
    write_stream_count(5'd16);
    for (int i = 0; i < tkm_pkg::MAX_STREAMS_DEFAULT; i++) begin
      if (lane_state[i] == LANE_WAIT) begin
        send_event_word(event_word(i[3:0], fresh_clock(), tkm_pkg::FIELD_W'($urandom),
                                   tkm_pkg::FIELD_W'($urandom), 1'b0));
      end
    end
    run_traffic(150, 0);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_traffic(100, 0);
  endtask

  // Downstream stops for a long stretch while words keep coming, so the
  // output register fills and the input stalls; then the sender waits for
  // everything to come out.
  task automatic test_backpressure();
    sender_idles   = 1'b0;
    receiver_idles = 1'b1;
    hold_req       = 1'b1;
    run_traffic(80, 0);
    wait_for_drain();
    sender_idles   = 1'b1;
  endtask

  // Count register at and beyond its range, and shrinking while streams
  // above the new count still hold heads.
  task automatic test_count_extremes();
    write_stream_count(5'd31);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_traffic(120, 0);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    write_stream_count(5'd17);
    run_traffic(80, 0);
    write_stream_count(5'd5);
    run_traffic(80, 0);
    write_stream_count(5'd3);
    sender_idles = 1'b0;
    run_traffic(80, 0);
    sender_idles = 1'b1;
    write_stream_count(5'd16);
    run_traffic(100, 0);
  endtask

  // Streams end one by one amid traffic, then the rest are closed so the
  // held heads flush out. After that nothing may come out at all.
  task automatic test_stream_endings();
    int s;
    run_traffic(150, 30);
    forever begin
      s = random_waiting_stream();
      if (s < 0) break;
      send_event_word(event_word(s[3:0], {$urandom, $urandom}, tkm_pkg::FIELD_W'($urandom),
                                 tkm_pkg::FIELD_W'($urandom), 1'b1));
    end
    for (int i = 0; i < 6; i++) begin
      send_event_word(event_word(4'($urandom_range(0, 15)), {$urandom, $urandom},
                                 tkm_pkg::FIELD_W'($urandom), tkm_pkg::FIELD_W'($urandom),
                                 1'($urandom_range(0, 1))));
    end
  endtask

  // ------------------------------------------------------------------
  // Result checking and downstream stall
  // ------------------------------------------------------------------

  // Every merged word taken from the block is compared with the oldest
  // owed word. After each one the receiver draws a stall, and it also
  // stalls for as long as a hold-off is running.
  initial begin
    int           stall_left;
    merged_word_t exp;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (merged_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("%0t: unexpected word: stream %0d delta %h fsm %h code %h back %b",
                     $realtime, source_stream, time_delta, fsm_out, code_out,
                     time_backwards);
          end
        end else begin
          exp = merged_q.pop_front();
          if (source_stream !== exp.src || time_delta !== exp.delta ||
              fsm_out !== exp.fsm || code_out !== exp.code ||
              time_backwards !== exp.backwards) begin
            error_count++;
            if (error_count <= 10) begin
              $display("%0t: mismatch: expected stream %0d delta %h fsm %h code %h back %b",
                       $realtime, exp.src, exp.delta, exp.fsm, exp.code, exp.backwards);
              $display("%0t:           got stream %0d delta %h fsm %h code %h back %b",
                       $realtime, source_stream, time_delta, fsm_out, code_out,
                       time_backwards);
            end
          end
        end
        stall_left = receiver_idles ? $urandom_range(0, GAP_MAX) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_active || (stall_left != 0);
    end
  end

  // The long hold-off counts its own cycles once requested.
  initial begin
    forever begin
      wait (hold_req);
      @(posedge clk);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
      hold_req = 1'b0;
    end
  end

  // A run in which no handshake of any kind happens for too long is hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words still owed",
               $realtime, QUIET_LIMIT, merged_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------

  initial begin
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    stream_count <= 5'd1;
    in_valid     <= 1'b0;
    stream_index <= '0;
    event_clock  <= '0;
    event_fsm    <= '0;
    event_code   <= '0;
    stream_ends  <= 1'b0;
    for (int i = 0; i < tkm_pkg::MAX_STREAMS_DEFAULT; i++) begin
      heads[i]      = '0;
      lane_state[i] = LANE_WAIT;
    end
    origin_clock      = '0;
    origin_taken      = 1'b0;
    last_merged_clock = '0;
    merge_width       = 5'd1;
    sender_idles      = 1'b1;
    receiver_idles    = 1'b1;
    error_count       = 0;
    quiet_cycles      = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_stream();
    test_zero_count();
    test_two_streams();
    test_full_width();
    test_backpressure();
    test_count_extremes();
    test_stream_endings();

    // Drain and leave room for any stray word before the verdict.
    wait_for_drain();
    if (error_count == 0 && merged_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
